// ===== hdl/lsbp_pkg.sv =====
// Shared types and constants for the LSB-first bit packer.
`timescale 1ns / 1ps

package lsbp_pkg;

    // Default geometry of the block.
    localparam int STORE_BYTES_DEF    = 256;
    localparam int MAX_FIELD_BITS_DEF = 32;

    // Width and reset value of the stream length register.
    localparam int          LEN_W     = 9;
    localparam logic [8:0]  LEN_RESET = 9'd256;

    // Operation codes carried by an input beat.
    typedef enum logic [1:0] {
        FUNC_WRITE   = 2'd0,
        FUNC_READ    = 2'd1,
        FUNC_RESTART = 2'd2,
        FUNC_LOAD    = 2'd3
    } func_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BYTE,
        ST_ALIGN,
        ST_DONE
    } state_t;

    // Input beat payload.
    typedef struct packed {
        func_t       func;
        logic [31:0] field_value;
        logic [5:0]  bit_count;
        logic [7:0]  byte_address;
        logic        clear_store;
    } in_beat_t;

    // Result beat payload.
    typedef struct packed {
        logic [31:0] read_data;
        logic        success;
    } out_beat_t;

endpackage

// ===== hdl/lsb_first_bit_packer.sv =====
// Top level of the LSB-first bit packer: config register, sequencer, store and result register.
`timescale 1ns / 1ps

// Variable-width bit-field packer and unpacker over a byte store, LSB-first.
// Input beats (s_valid/s_ready, s_beat) carry one operation: write bits, read
// bits, restart, or load byte. Every input beat produces exactly one result
// beat (m_valid/m_ready, m_beat) with the read data and a success flag.
// A field write reads and writes back the store bytes it touches, a field read
// only reads them, one byte per cycle through the single memory read port;
// the bytes touched number nbytes = ceil((offset mod 8 + bit_count) / 8), at
// most five for 32 bits. A read then realigns the gathered bytes in an align step.
// Zero-count, failing, non-clearing restart and load items skip the byte walk
// and go straight to the result. The next beat is accepted once the result has
// moved to the output register and the sequencer is back in idle.
// After reset, and on a restart that clears the store, the store is zeroed
// by a sweep over all STORE_BYTES bytes during which no input beat is accepted;
// the result of a clearing restart follows the sweep.
// A finished result waits in the output register while the sequencer goes
// back to accept the next beat; if the receiver stalls, the next result is
// held inside the sequencer until the output register frees.
// cfg_wr_en writes the stream length in bytes into a register checked at each field beat.
module lsb_first_bit_packer #(
    parameter int STORE_BYTES    = lsbp_pkg::STORE_BYTES_DEF,
    parameter int MAX_FIELD_BITS = lsbp_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [lsbp_pkg::LEN_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lsbp_pkg::in_beat_t         s_beat,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lsbp_pkg::out_beat_t        m_beat
);

    import lsbp_pkg::*;

    localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    logic [LEN_W-1:0] stream_len_reg;
    logic             m_valid_reg;
    out_beat_t        m_beat_reg;

    logic             res_valid;
    out_beat_t        res_beat;
    logic             slot_free;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [7:0]       rd_data;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [7:0]       wr_data;

    // Stream length register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stream_len_reg <= LEN_RESET;
        end else if (cfg_wr_en) begin
            stream_len_reg <= cfg_wr_data;
        end
    end

    lsbp_ctrl #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_FIELD_BITS (MAX_FIELD_BITS),
        .AW             (AW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .stream_len (stream_len_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_beat     (s_beat),
        .res_valid  (res_valid),
        .res_beat   (res_beat),
        .slot_free  (slot_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    lsbp_store #(
        .DEPTH (STORE_BYTES),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Output register; it frees when empty or when its beat is taken.
    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (slot_free) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (slot_free && res_valid) begin
            m_beat_reg <= res_beat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_beat  = m_beat_reg;

endmodule

// ===== hdl/lsbp_store.sv =====
// Byte store: simple dual-port memory with a registered read port.
`timescale 1ns / 1ps

module lsbp_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data
);

    logic [7:0] store_reg [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/lsbp_ctrl.sv =====
// Sequencer that walks a field byte by byte through the store, and clears and loads store bytes.
`timescale 1ns / 1ps

module lsbp_ctrl #(
    parameter int STORE_BYTES    = 256,
    parameter int MAX_FIELD_BITS = 32,
    parameter int AW             = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [lsbp_pkg::LEN_W-1:0] stream_len,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lsbp_pkg::in_beat_t       s_beat,
    output logic                     res_valid,
    output lsbp_pkg::out_beat_t      res_beat,
    input  logic                     slot_free,
    output logic                     rd_en,
    output logic [AW-1:0]            rd_addr,
    input  logic [7:0]               rd_data,
    output logic                     wr_en,
    output logic [AW-1:0]            wr_addr,
    output logic [7:0]               wr_data
);

    import lsbp_pkg::*;

    localparam int OW    = $clog2(STORE_BYTES * 8 + 1);
    localparam int LW    = (OW > 12) ? OW : 12;
    localparam int NBMAX = (MAX_FIELD_BITS + 14) / 8;
    localparam int NW    = $clog2(NBMAX + 1);
    localparam int SW    = NBMAX * 8;
    localparam int SHW   = $clog2(SW);

    state_t         state_reg, state_next;
    logic [OW-1:0]  offset_reg;
    logic [AW-1:0]  addr_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic           clr_reply_reg;
    logic           is_read_reg;
    logic [2:0]     shift_reg;
    logic [5:0]     cnt_reg;
    logic [NW-1:0]  rem_reg;
    logic [NW-1:0]  nb_reg;
    logic [SW-1:0]  wv_reg;
    logic [SW-1:0]  acc_reg;
    logic [31:0]    res_data_reg;
    logic           res_ok_reg;

    logic           accept;
    logic           is_field;
    logic           fits;
    logic           go_field;
    logic           load_in_range;
    logic [2:0]     in_shift;
    logic [AW-1:0]  in_addr;
    logic [LW-1:0]  len_bits;
    logic [LW-1:0]  store_bits;
    logic [LW-1:0]  limit_bits;
    logic [LW-1:0]  off_ext;
    logic [6:0]     span_sum;
    logic [NW-1:0]  in_nbytes;
    logic [SW-1:0]  in_wv;
    logic [SHW-1:0] align_sh;
    logic [SW-1:0]  aligned;
    logic           clr_last;
    logic           byte_last;

    // Bits below a given count.
    function automatic logic [SW-1:0] low_mask(input logic [5:0] n);
        logic [SW-1:0] m;
        for (int i = 0; i < SW; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    // Decode of the beat offered at the input.
    assign accept     = s_valid && (state_reg == ST_IDLE);
    assign is_field   = (s_beat.func == FUNC_WRITE) || (s_beat.func == FUNC_READ);
    assign in_shift   = offset_reg[2:0];
    assign in_addr    = AW'(offset_reg >> 3);
    assign len_bits   = LW'({stream_len, 3'b000});
    assign store_bits = LW'(STORE_BYTES * 8);
    assign limit_bits = (len_bits > store_bits) ? store_bits : len_bits;
    assign off_ext    = LW'(offset_reg);
    assign fits       = (7'(s_beat.bit_count) <= 7'(MAX_FIELD_BITS))
                     && (off_ext < limit_bits)
                     && ((limit_bits - off_ext) >= LW'(s_beat.bit_count));
    assign go_field   = is_field && (s_beat.bit_count != 6'd0) && fits;
    assign span_sum   = 7'(in_shift) + 7'(s_beat.bit_count) + 7'd7;
    assign in_nbytes  = NW'(span_sum >> 3);
    assign in_wv      = (SW'(s_beat.field_value) & low_mask(s_beat.bit_count)) << in_shift;
    assign load_in_range = 32'(s_beat.byte_address) < STORE_BYTES;

    // Realignment of the bytes gathered by a read.
    assign align_sh   = SHW'((NBMAX - int'(nb_reg)) * 8 + int'(shift_reg));
    assign aligned    = (acc_reg >> align_sh) & low_mask(cnt_reg);

    assign clr_last   = (clr_addr_reg == AW'(STORE_BYTES - 1));
    assign byte_last  = (rem_reg == NW'(1));

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_last) begin
                    state_next = clr_reply_reg ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    if (go_field) begin
                        state_next = ST_BYTE;
                    end else if (s_beat.func == FUNC_RESTART && s_beat.clear_store) begin
                        state_next = ST_CLEAR;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_BYTE: begin
                if (byte_last) begin
                    state_next = is_read_reg ? ST_ALIGN : ST_DONE;
                end
            end
            ST_ALIGN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory port drive.
    always_comb begin
        s_ready   = 1'b0;
        res_valid = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = addr_reg + AW'(1);
        wr_en     = 1'b0;
        wr_addr   = addr_reg;
        wr_data   = rd_data | wv_reg[7:0];
        unique case (state_reg)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = 8'h00;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && go_field) begin
                    rd_en   = 1'b1;
                    rd_addr = in_addr;
                end
                if (s_valid && s_beat.func == FUNC_LOAD && load_in_range) begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(s_beat.byte_address);
                    wr_data = s_beat.field_value[7:0];
                end
            end
            ST_BYTE: begin
                rd_en = !byte_last;
                wr_en = !is_read_reg;
            end
            ST_ALIGN: begin
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign res_beat.read_data = res_data_reg;
    assign res_beat.success   = res_ok_reg;

    // State and control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            offset_reg    <= '0;
            clr_addr_reg  <= '0;
            clr_reply_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (accept) begin
                if (go_field) begin
                    offset_reg <= offset_reg + OW'(s_beat.bit_count);
                end
                if (s_beat.func == FUNC_RESTART) begin
                    offset_reg    <= '0;
                    clr_addr_reg  <= '0;
                    clr_reply_reg <= 1'b1;
                end
            end
        end
    end

    // Field datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            is_read_reg  <= (s_beat.func == FUNC_READ);
            shift_reg    <= in_shift;
            cnt_reg      <= s_beat.bit_count;
            rem_reg      <= in_nbytes;
            nb_reg       <= in_nbytes;
            addr_reg     <= in_addr;
            wv_reg       <= in_wv;
            res_data_reg <= '0;
            res_ok_reg   <= !is_field || (s_beat.bit_count == 6'd0) || fits;
        end
        if (state_reg == ST_BYTE) begin
            wv_reg   <= wv_reg >> 8;
            acc_reg  <= {rd_data, acc_reg[SW-1:8]};
            addr_reg <= addr_reg + AW'(1);
            rem_reg  <= rem_reg - NW'(1);
        end
        if (state_reg == ST_ALIGN) begin
            res_data_reg <= 32'(aligned);
        end
    end

endmodule

// ===== bench/tb_lsb_first_bit_packer.sv =====
// Self-checking testbench for the LSB-first bit packer with directed and random beat traffic.
`timescale 1ns / 1ps

module tb_lsb_first_bit_packer;
    import lsbp_pkg::*;

    localparam int STORE_BITS    = STORE_BYTES_DEF * 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [LEN_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_beat_t         s_beat;
    logic             m_valid;
    logic             m_ready;
    out_beat_t        m_beat;

    // Shadow copy of the packer state used to predict each result beat.
    logic [7:0]       shadow_store [STORE_BYTES_DEF];
    int unsigned      shadow_offset;
    logic [LEN_W-1:0] shadow_length;
    out_beat_t        predicted_beats [$];

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;

    lsb_first_bit_packer i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_beat      (s_beat),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_beat      (m_beat)
    );

    // 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Computes the result of one beat and advances the shadow state.
    function automatic out_beat_t compute_packer_result(input in_beat_t beat);
        out_beat_t   res;
        int unsigned usable;
        int unsigned pos;
        res.read_data = '0;
        res.success   = 1'b1;
        case (beat.func)
            FUNC_WRITE, FUNC_READ: begin
                usable = (shadow_length > STORE_BYTES_DEF) ? STORE_BITS : shadow_length * 8;
                if (beat.bit_count == 0) begin
                    // A zero-width access succeeds and touches nothing.
                end else if (beat.bit_count > MAX_FIELD_BITS_DEF || shadow_offset >= usable
                             || usable - shadow_offset < beat.bit_count) begin
                    res.success = 1'b0;
                end else begin
                    for (int i = 0; i < beat.bit_count; i++) begin
                        pos = shadow_offset + i;
                        if (beat.func == FUNC_WRITE) begin
                            if (beat.field_value[i])
                                shadow_store[pos / 8][pos % 8] = 1'b1;
                        end else begin
                            res.read_data[i] = shadow_store[pos / 8][pos % 8];
                        end
                    end
                    shadow_offset += beat.bit_count;
                end
            end
            FUNC_RESTART: begin
                shadow_offset = 0;
                if (beat.clear_store)
                    foreach (shadow_store[j]) shadow_store[j] = '0;
            end
            FUNC_LOAD: begin
                shadow_store[beat.byte_address] = beat.field_value[7:0];
            end
        endcase
        return res;
    endfunction

    function automatic in_beat_t make_beat(input func_t func, input logic [31:0] value,
                                           input logic [5:0] count, input logic [7:0] addr = '0,
                                           input logic clr = 1'b0);
        in_beat_t beat;
        beat.func         = func;
        beat.field_value  = value;
        beat.bit_count    = count;
        beat.byte_address = addr;
        beat.clear_store  = clr;
        return beat;
    endfunction

    function automatic in_beat_t random_beat();
        return make_beat(func_t'($urandom_range(3)), $urandom, 6'($urandom_range(63)),
                         8'($urandom_range(255)), 1'($urandom_range(1)));
    endfunction

    task automatic note_mismatch(input string what, input out_beat_t want, input out_beat_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected data %h success %b, got data %h success %b",
                     $time, what, want.read_data, want.success, got.read_data, got.success);
    endtask

    // Sends one input beat after a random gap and records its predicted result.
    task automatic send_beat(input in_beat_t beat);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge aclk);
            s_valid              <= 1'b0;
            s_beat.field_value   <= $urandom;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_beat  <= beat;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        predicted_beats.push_back(compute_packer_result(beat));
    endtask

    // Drops valid and waits until every predicted result has been seen.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (predicted_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_stream_length(input logic [LEN_W-1:0] len);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        shadow_length = len;
    endtask

    // Full-width, single-bit and byte-straddling fields written and read back.
    task automatic test_field_extremes();
        send_beat(make_beat(FUNC_WRITE, 32'hFFFF_FFFF, 6'd32));
        send_beat(make_beat(FUNC_WRITE, 32'h0000_0001, 6'd1));
        send_beat(make_beat(FUNC_WRITE, 32'hFFFF_FFFA, 6'd3));
        send_beat(make_beat(FUNC_WRITE, 32'hDEAD_BEEF, 6'd32));
        send_beat(make_beat(FUNC_RESTART, 32'h0, 6'd0, 8'd0, 1'b0));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd32));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd1));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd3));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd32));
    endtask

    // Zero-width accesses succeed; counts wider than a field fail.
    task automatic test_count_corners();
        send_beat(make_beat(FUNC_WRITE, 32'hFFFF_FFFF, 6'd0));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd0));
        send_beat(make_beat(FUNC_WRITE, 32'h1234_5678, 6'd33));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd63));
    endtask

    // Loaded bytes and written fields combine by OR.
    task automatic test_load_and_overlay();
        send_beat(make_beat(FUNC_RESTART, 32'h0, 6'd0, 8'd0, 1'b1));
        send_beat(make_beat(FUNC_LOAD, 32'hFFFF_FF0F, 6'd0, 8'd0));
        send_beat(make_beat(FUNC_LOAD, 32'h0000_00A5, 6'd0, 8'd255));
        send_beat(make_beat(FUNC_WRITE, 32'h0000_00F0, 6'd8));
        send_beat(make_beat(FUNC_RESTART, 32'h0, 6'd0, 8'd0, 1'b0));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd8));
    endtask

    // Accesses that run past the configured stream length fail without side effects.
    task automatic test_stream_length_limits();
        write_stream_length('0);
        send_beat(make_beat(FUNC_WRITE, 32'h1, 6'd1));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd0));
        write_stream_length(9'd1);
        send_beat(make_beat(FUNC_RESTART, 32'h0, 6'd0, 8'd0, 1'b0));
        send_beat(make_beat(FUNC_WRITE, 32'h0000_00C3, 6'd8));
        send_beat(make_beat(FUNC_WRITE, 32'h1, 6'd1));
        send_beat(make_beat(FUNC_RESTART, 32'h0, 6'd0, 8'd0, 1'b0));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd9));
        send_beat(make_beat(FUNC_READ, 32'h0, 6'd8));
    endtask

    // Mostly pack-then-unpack runs, with long runs to the end, loads and noise.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned sent;
        int unsigned kind;
        int unsigned n_fields;
        logic [5:0]  counts [$];
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(9);
            counts.delete();
            if (kind <= 5) begin
                // Pack a run of fields, rewind, then unpack the same widths.
                send_beat(make_beat(FUNC_RESTART, $urandom, 6'($urandom_range(63)),
                                    8'($urandom_range(255)), $urandom_range(3) != 0));
                n_fields = $urandom_range(1, 20);
                repeat (n_fields) begin
                    counts.push_back(6'(($urandom_range(7) == 0) ? $urandom_range(63)
                                                                 : $urandom_range(1, 32)));
                    send_beat(make_beat(FUNC_WRITE, $urandom, counts[$]));
                end
                send_beat(make_beat(FUNC_RESTART, $urandom, 6'($urandom_range(63)),
                                    8'($urandom_range(255)), 1'b0));
                foreach (counts[k]) send_beat(make_beat(FUNC_READ, $urandom, counts[k]));
                sent += 2 * n_fields + 2;
            end else if (kind == 6) begin
                // Wide fields walk the offset to the end of the stream.
                send_beat(make_beat(FUNC_RESTART, $urandom, 6'd0, 8'd0,
                                    1'($urandom_range(1))));
                repeat (80)
                    send_beat(make_beat($urandom_range(1) ? FUNC_WRITE : FUNC_READ, $urandom,
                                        6'($urandom_range(28, 32))));
                sent += 81;
            end else if (kind == 7) begin
                // Fill bytes from outside, then unpack from the start.
                n_fields = $urandom_range(1, 8);
                repeat (n_fields)
                    send_beat(make_beat(FUNC_LOAD, $urandom, 6'($urandom_range(63)),
                                        8'(($urandom_range(7) == 0) ? $urandom_range(255)
                                                                    : $urandom_range(15))));
                send_beat(make_beat(FUNC_RESTART, $urandom, 6'd0, 8'd0, 1'b0));
                repeat (n_fields)
                    send_beat(make_beat(FUNC_READ, $urandom, 6'($urandom_range(1, 32))));
                sent += 2 * n_fields + 1;
            end else begin
                repeat (8) send_beat(random_beat());
                sent += 8;
            end
        end
    endtask

    // Result beats are compared against the oldest prediction.
    always @(posedge aclk) begin : check_results
        out_beat_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (predicted_beats.size() == 0) begin
                want = '0;
                note_mismatch("unexpected result beat", want, m_beat);
            end else begin
                want = predicted_beats.pop_front();
                if (m_beat.read_data !== want.read_data || m_beat.success !== want.success)
                    note_mismatch("result mismatch", want, m_beat);
            end
        end
    end

    // Receiver readiness, redrawn every cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_lsb_first_bit_packer failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_beat      = '0;
        m_ready     = 1'b0;
        tx_idle_pct = 32;
        rx_idle_pct = 45;
        foreach (shadow_store[j]) shadow_store[j] = '0;
        shadow_offset = 0;
        shadow_length = LEN_RESET;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_count_corners();
        test_load_and_overlay();
        test_stream_length_limits();

        write_stream_length(LEN_RESET);
        test_random_traffic(700);

        tx_idle_pct = 45;
        rx_idle_pct = 32;
        write_stream_length(9'($urandom_range(2, 32)));
        test_random_traffic(350);
        write_stream_length(9'($urandom_range(33, 255)));
        test_random_traffic(350);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_stream_length(9'h1FF);
        test_random_traffic(600);

        wait_idle();
        if (mismatch_count == 0)
            $display("tb_lsb_first_bit_packer passed");
        else
            $display("tb_lsb_first_bit_packer failed");
        $finish;
    end

endmodule
